FILE: src/hpw_pkg.sv
`default_nettype none
package hpw_pkg;

  // Field widths
  localparam int CNT_W   = 18;
  localparam int RST_W   = 16;
  localparam int LOST_W  = 4;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  // Channels that have configuration bytes
  localparam int CFG_CHANNELS = 4;

  // Request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  // Event kinds
  localparam logic EV_PING  = 1'b0;
  localparam logic EV_RELAY = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ACTIVE  = 3'd0;
  localparam logic [2:0] REG_TEST    = 3'd1;
  localparam logic [2:0] REG_LOST    = 3'd2;
  localparam logic [2:0] REG_RESTART = 3'd3;
  localparam logic [2:0] REG_SETTLE  = 3'd4;

  // Channel unit operations
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [1:0] channel;
    logic       ping_ok;
  } in_t;

  typedef struct packed {
    logic             event_kind;
    logic [1:0]       target_channel;
    logic             relay_on;
    logic [RST_W-1:0] restart_total;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [3:0]  active_mask;
    logic [31:0] test_periods;
    logic [15:0] lost_limits;
    logic [31:0] restart_waits;
    logic [31:0] settle_waits;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0]  countdown;
    logic              started;
    logic              restart_mode;
    logic              awaiting;
    logic [LOST_W-1:0] lost_count;
    logic [RST_W-1:0]  restart_count;
  } chan_t;

  typedef struct packed {
    logic ev_valid;
    logic ev_kind;
    logic ev_relay;
  } unit_res_t;

endpackage
`default_nettype wire

FILE: src/hpw_unit.sv
`default_nettype none
// Shared per-channel update: one multiply (seconds to ticks), one decrement,
// small compares. Applied to one channel at a time by the sequencer.
module hpw_unit #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  wire logic [1:0]       op,
  input  wire logic             ping_ok,
  input  wire logic [1:0]       ch_sel,
  input  wire logic             ch_cfg,
  input  wire hpw_pkg::cfg_t    cfg,
  input  wire hpw_pkg::chan_t   chan_cur,
  output hpw_pkg::chan_t        chan_upd,
  output hpw_pkg::unit_res_t    res
);

  logic                        active;
  logic [7:0]                  test_sec;
  logic [7:0]                  restart_sec;
  logic [7:0]                  settle_sec;
  logic [3:0]                  limit;
  logic [hpw_pkg::LOST_W:0]    lost_inc;
  logic                        exceed;
  logic [7:0]                  mult_sec;
  logic [hpw_pkg::CNT_W-1:0]   load_val;
  logic [hpw_pkg::CNT_W-1:0]   dec_val;
  logic                        due;
  logic [hpw_pkg::RST_W-1:0]   rst_sat;

  assign active      = ch_cfg && cfg.active_mask[ch_sel];
  assign test_sec    = cfg.test_periods[8*ch_sel +: 8];
  assign restart_sec = cfg.restart_waits[8*ch_sel +: 8];
  assign settle_sec  = cfg.settle_waits[8*ch_sel +: 8];
  assign limit       = cfg.lost_limits[4*ch_sel +: 4];

  // Lost count compared one bit wider so a limit of fifteen works
  assign lost_inc = {1'b0, chan_cur.lost_count} + 5'd1;
  assign exceed   = lost_inc > {1'b0, limit};

  // Operand select for the shared multiplier
  always_comb begin
    case (op)
      hpw_pkg::OP_STEP:   mult_sec = settle_sec;
      hpw_pkg::OP_REPORT: mult_sec = (!ping_ok && exceed) ? restart_sec : test_sec;
      default:            mult_sec = test_sec;
    endcase
  end

  assign load_val = hpw_pkg::CNT_W'(32'(mult_sec) * 32'(TICKS_PER_SECOND));

  // Saturating countdown; due once it reaches zero
  assign dec_val = (chan_cur.countdown == '0) ? '0 : chan_cur.countdown - 1'b1;
  assign due     = (dec_val == '0);
  assign rst_sat = (chan_cur.restart_count == '1) ? chan_cur.restart_count
                                                  : chan_cur.restart_count + 1'b1;

  always_comb begin
    chan_upd = chan_cur;
    res      = '0;
    case (op)
      hpw_pkg::OP_LOAD: begin
        if (!active) begin
          chan_upd.started  = 1'b0;
          chan_upd.awaiting = 1'b0;
        end else if (!chan_cur.started) begin
          chan_upd.countdown = load_val;
          chan_upd.started   = 1'b1;
        end
      end
      hpw_pkg::OP_STEP: begin
        if (active) begin
          chan_upd.countdown = dec_val;
          if (due) begin
            if (chan_cur.restart_mode) begin
              chan_upd.restart_mode = 1'b0;
              chan_upd.countdown    = load_val;
              res.ev_valid          = 1'b1;
              res.ev_kind           = hpw_pkg::EV_RELAY;
              res.ev_relay          = 1'b0;
            end else if (!chan_cur.awaiting) begin
              chan_upd.awaiting = 1'b1;
              res.ev_valid      = 1'b1;
              res.ev_kind       = hpw_pkg::EV_PING;
              res.ev_relay      = 1'b0;
            end
          end
        end
      end
      hpw_pkg::OP_REPORT: begin
        if (chan_cur.awaiting) begin
          chan_upd.awaiting  = 1'b0;
          chan_upd.countdown = load_val;
          if (ping_ok) begin
            chan_upd.lost_count = '0;
          end else if (exceed) begin
            chan_upd.lost_count    = '0;
            chan_upd.restart_count = rst_sat;
            chan_upd.restart_mode  = 1'b1;
            res.ev_valid           = 1'b1;
            res.ev_kind            = hpw_pkg::EV_RELAY;
            res.ev_relay           = 1'b1;
          end else begin
            chan_upd.lost_count = lost_inc[hpw_pkg::LOST_W-1:0];
          end
        end
      end
      default: begin
        chan_upd = chan_cur;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/hpw_seq.sv
`default_nettype none
// Sequencer: walks the channels through the shared unit, holds the channel
// state, and stages results so the last one of an input can be marked.
module hpw_seq #(
  parameter int CHANNELS         = 4,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire hpw_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output hpw_pkg::out_t      out_data,
  input  wire hpw_pkg::cfg_t cfg
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_STEP   = 3'd2;
  localparam logic [2:0] S_REPORT = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                ok_r, ok_nxt;
  hpw_pkg::out_t       pend_r, pend_nxt;
  logic                pend_v_r, pend_v_nxt;
  hpw_pkg::out_t       out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  hpw_pkg::chan_t      chan_r [CHANNELS];

  hpw_pkg::chan_t      chan_upd;
  hpw_pkg::unit_res_t  res;
  logic [1:0]          op;
  logic [3:0]          cur_ch;
  logic [3:0]          rep_ch;
  logic                ch_cfg;
  logic                out_free;
  logic                go;
  logic                do_step;
  logic                chan_we;
  hpw_pkg::out_t       new_ev;

  assign cur_ch   = 4'(idx_r);
  assign rep_ch   = 4'(in_data.channel);
  assign ch_cfg   = cur_ch < 4'(hpw_pkg::CFG_CHANNELS);
  assign out_free = !out_valid_r || !out_stall;
  // A staged result must be able to move to the output before a new one
  assign go       = !pend_v_r || out_free;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    case (state_r)
      S_STEP:   op = hpw_pkg::OP_STEP;
      S_REPORT: op = hpw_pkg::OP_REPORT;
      default:  op = hpw_pkg::OP_LOAD;
    endcase
  end

  hpw_unit #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_unit (
    .op       (op),
    .ping_ok  (ok_r),
    .ch_sel   (cur_ch[1:0]),
    .ch_cfg   (ch_cfg),
    .cfg      (cfg),
    .chan_cur (chan_r[idx_r]),
    .chan_upd (chan_upd),
    .res      (res)
  );

  always_comb begin
    new_ev                = '0;
    new_ev.event_kind     = res.ev_kind;
    new_ev.target_channel = cur_ch[1:0];
    new_ev.relay_on       = res.ev_relay;
    new_ev.restart_total  = chan_upd.restart_count;
  end

  // Sequencer and result staging
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ok_nxt        = ok_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    do_step       = 1'b0;
    chan_we       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ok_nxt = in_data.ping_ok;
          if (in_data.req_type == hpw_pkg::REQ_TICK) begin
            idx_nxt   = '0;
            state_nxt = S_LOAD;
          end else if (rep_ch < 4'(CHANNELS)) begin
            idx_nxt   = rep_ch[IW-1:0];
            state_nxt = S_REPORT;
          end
        end
      end
      S_LOAD: begin
        chan_we   = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (go) begin
          do_step = 1'b1;
          if (idx_r == IW'(CHANNELS - 1)) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_LOAD;
          end
        end
      end
      S_REPORT: begin
        if (go) begin
          do_step   = 1'b1;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new event pushes the staged one out, not last
    if (do_step) begin
      chan_we = 1'b1;
      if (res.ev_valid) begin
        if (pend_v_r) begin
          out_nxt       = pend_r;
          out_nxt.last  = 1'b0;
          out_valid_nxt = 1'b1;
        end
        pend_nxt   = new_ev;
        pend_v_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    ok_r   <= ok_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Channel state, one entry per channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        chan_r[i] <= '0;
      end
    end else if (chan_we) begin
      chan_r[idx_r] <= chan_upd;
    end
  end

endmodule
`default_nettype wire

FILE: src/host_ping_watchdog.sv
// Ping/restart watchdog for up to CHANNELS network hosts.
// Input channel (in_valid/in_stall/in_data): each transfer is either a
// one-millisecond tick or a ping outcome for one channel. On a tick every
// channel is visited in order; a due channel requests a ping, or ends a
// restart by switching its relay off. A failed ping past the lost limit
// switches the relay on and starts a restart wait.
// Result channel (out_valid/out_stall/out_data): ping requests and relay
// switches, the final one of each input marked with last.
// Timing: in_stall is high while an input is processed; a tick gives each
// channel a load and then a step. One channel update per cycle, unless it
// waits on the output, runs through a single multiply and decrement unit.
// A stalled receiver holds its result; one more result is staged inside,
// and the sequencer waits when both are full.
// Configuration is to be written over the APB port only while the block
// is idle; the user must keep to this, the block does not enforce it.
// Reset (rst_n low, synchronous) clears the control and configuration
// registers and all channel state; result payloads are loaded before use.
`default_nettype none
module host_ping_watchdog #(
  parameter int CHANNELS         = 4,
  parameter int TICKS_PER_SECOND = 1000
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire hpw_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output hpw_pkg::out_t                   out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [hpw_pkg::ADDR_W-1:0] paddr,
  input  wire logic [hpw_pkg::DATA_W-1:0] pwdata,
  output logic      [hpw_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [3:0]  active_r;
  logic [31:0] test_r;
  logic [15:0] lost_r;
  logic [31:0] restart_r;
  logic [31:0] settle_r;
  logic [2:0]  reg_idx;
  logic        wr_en;
  hpw_pkg::cfg_t cfg;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      test_r    <= '0;
      lost_r    <= '0;
      restart_r <= '0;
      settle_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        hpw_pkg::REG_ACTIVE:  active_r  <= pwdata[3:0];
        hpw_pkg::REG_TEST:    test_r    <= pwdata;
        hpw_pkg::REG_LOST:    lost_r    <= pwdata[15:0];
        hpw_pkg::REG_RESTART: restart_r <= pwdata;
        hpw_pkg::REG_SETTLE:  settle_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      hpw_pkg::REG_ACTIVE:  prdata = {28'd0, active_r};
      hpw_pkg::REG_TEST:    prdata = test_r;
      hpw_pkg::REG_LOST:    prdata = {16'd0, lost_r};
      hpw_pkg::REG_RESTART: prdata = restart_r;
      hpw_pkg::REG_SETTLE:  prdata = settle_r;
      default:              prdata = '0;
    endcase
  end

  assign cfg.active_mask   = active_r;
  assign cfg.test_periods  = test_r;
  assign cfg.lost_limits   = lost_r;
  assign cfg.restart_waits = restart_r;
  assign cfg.settle_waits  = settle_r;

  hpw_seq #(
    .CHANNELS        (CHANNELS),
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg       (cfg)
  );

endmodule
`default_nettype wire
